// ===== design/imaxpq_pkg.sv =====
// Shared types, constants and the ordering function of the indexed max priority queue.
`default_nettype none
package imaxpq_pkg;

	localparam int SLOTS = 1024;
	localparam int IDW   = 10;
	localparam int KEYW  = 32;
	localparam int CNTW  = 11;
	localparam int ELEW  = IDW + KEYW;

	localparam logic [1:0] ACT_INSERT  = 2'd0;
	localparam logic [1:0] ACT_EXTRACT = 2'd1;
	localparam logic [1:0] ACT_UPDATE  = 2'd2;
	localparam logic [1:0] ACT_REMOVE  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	// Request to the position map: one read and one write port.
	typedef struct packed {
		logic            rd_en;
		logic [IDW-1:0]  rd_addr;
		logic            wr_en;
		logic [IDW-1:0]  wr_addr;
		logic [CNTW-1:0] wr_data;
	} pm_req_t;

	// True when entry a ranks above entry b: larger key, then lower identifier.
	function automatic logic outranks(input logic [IDW-1:0] ida,
			input logic signed [KEYW-1:0] ka, input logic [IDW-1:0] idb,
			input logic signed [KEYW-1:0] kb);
		return (ka > kb) || ((ka == kb) && (ida < idb));
	endfunction

endpackage
`default_nettype wire

// ===== design/imaxpq_posmap.sv =====
// Identifier-to-slot map memory with its clearing pass after reset.
`default_nettype none
module imaxpq_posmap (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire imaxpq_pkg::pm_req_t        req,
	output logic [imaxpq_pkg::CNTW-1:0]     rdata,
	output logic                            busy
);

	logic [imaxpq_pkg::CNTW-1:0] mem [0:imaxpq_pkg::SLOTS-1];
	logic [imaxpq_pkg::CNTW-1:0] clr_q;
	logic                        we;
	logic [imaxpq_pkg::IDW-1:0]  waddr;
	logic [imaxpq_pkg::CNTW-1:0] wdata;

	// The top bit of the sweep counter marks the end of the clearing pass.
	assign busy = !clr_q[imaxpq_pkg::CNTW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		if (busy) begin
			we    = 1'b1;
			waddr = clr_q[imaxpq_pkg::IDW-1:0];
			wdata = '0;
		end else begin
			we    = req.wr_en;
			waddr = req.wr_addr;
			wdata = req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.rd_en) begin
			rdata <= mem[req.rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== design/indexed_max_priority_queue.sv =====
// Top level of the indexed max priority queue: heap memory, sequencer and ports.
`default_nettype none
// An indexed binary max-heap of up to 1024 entries (identifier, signed Q16.16 key),
// ordered by larger key and then lower identifier, with one result per request.
// One request is worked at a time. Every request passes through entry (map read,
// decision) and finish; in between, a sift up works each level as a read of the parent
// and a sift down works each level as reads of the children, in the single-read-port heap
// memory, each followed by a compare and a write back. After reset the position map is
// swept clear over its 1024 slots, during which req_stall stays high; configuration
// writes are taken at any time.
module indexed_max_priority_queue (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire logic [1:0]                         action,
	input  wire logic [imaxpq_pkg::IDW-1:0]         item_id,
	input  wire logic signed [imaxpq_pkg::KEYW-1:0] key_value,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output logic [2:0]                              status,
	output logic [imaxpq_pkg::IDW-1:0]              taken_id,
	output logic signed [imaxpq_pkg::KEYW-1:0]      taken_key,
	output logic                                    top_valid,
	output logic [imaxpq_pkg::IDW-1:0]              top_id,
	output logic signed [imaxpq_pkg::KEYW-1:0]      top_key,
	output logic [imaxpq_pkg::CNTW-1:0]             entry_total
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MAP   = 4'd1;
	localparam logic [3:0] S_LAST  = 4'd2;
	localparam logic [3:0] S_UP    = 4'd3;
	localparam logic [3:0] S_UPCMP = 4'd4;
	localparam logic [3:0] S_DOWN  = 4'd5;
	localparam logic [3:0] S_DOWNL = 4'd6;
	localparam logic [3:0] S_DOWNR = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	localparam logic [2:0] CFG_CAP_ADDR = 3'd0;
	localparam logic [imaxpq_pkg::CNTW-1:0] SLOTS_C = imaxpq_pkg::CNTW'(imaxpq_pkg::SLOTS);

	// Configuration.
	logic [imaxpq_pkg::CNTW-1:0] cap_q;
	logic [imaxpq_pkg::CNTW-1:0] limit;

	assign pready = 1'b1;
	assign prdata = (paddr == CFG_CAP_ADDR) ? {{(32-imaxpq_pkg::CNTW){1'b0}}, cap_q} : '0;
	assign limit  = (cap_q > SLOTS_C) ? SLOTS_C : cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= SLOTS_C;
		end else if (psel && penable && pwrite && paddr == CFG_CAP_ADDR) begin
			cap_q <= pwdata[imaxpq_pkg::CNTW-1:0];
		end
	end

	// Heap memory holds {identifier, key} per slot.
	logic [imaxpq_pkg::ELEW-1:0] heap_mem [0:imaxpq_pkg::SLOTS-1];
	logic                        heap_we, heap_re;
	logic [imaxpq_pkg::IDW-1:0]  heap_waddr, heap_raddr;
	logic [imaxpq_pkg::ELEW-1:0] heap_wdata, heap_rdata;

	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
		if (heap_re) begin
			heap_rdata <= heap_mem[heap_raddr];
		end
	end

	imaxpq_pkg::pm_req_t         pm_req;
	logic [imaxpq_pkg::CNTW-1:0] pm_rdata;
	logic                        pm_busy;

	imaxpq_posmap u_posmap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pm_req),
		.rdata  (pm_rdata),
		.busy   (pm_busy)
	);

	// Sequencer state.
	logic [3:0]                         state_q, state_nxt;
	logic [1:0]                         act_q;
	logic [imaxpq_pkg::IDW-1:0]         id_q, e_id_q, best_id_q, top_id_q, taken_id_q;
	logic signed [imaxpq_pkg::KEYW-1:0] key_q, e_key_q, best_key_q, top_key_q, taken_key_q;
	logic [imaxpq_pkg::IDW-1:0]         pos_q;
	logic [imaxpq_pkg::CNTW-1:0]        cnt_q;
	logic                               settle_q, bsel_q, has_right_q;
	logic [2:0]                         status_q;
	logic                               rsp_valid_q;
	logic [2:0]                         rsp_status_q;
	logic [imaxpq_pkg::IDW-1:0]         rsp_taken_id_q, rsp_top_id_q;
	logic signed [imaxpq_pkg::KEYW-1:0] rsp_taken_key_q, rsp_top_key_q;
	logic [imaxpq_pkg::CNTW-1:0]        rsp_cnt_q;

	logic                               accept, rsp_free;
	logic                               map_present;
	logic [imaxpq_pkg::IDW-1:0]         map_slot;
	logic [imaxpq_pkg::CNTW-1:0]        last;
	logic [imaxpq_pkg::IDW-1:0]         rd_id, parent, left10, right10;
	logic signed [imaxpq_pkg::KEYW-1:0] rd_key;
	logic [imaxpq_pkg::CNTW-1:0]        left11, right11;
	logic                               e_wins_parent, left_wins, right_wins;

	assign req_stall   = (state_q != S_IDLE) || pm_busy;
	assign accept      = req_valid && !req_stall;
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign map_present = pm_rdata[imaxpq_pkg::CNTW-1];
	assign map_slot    = pm_rdata[imaxpq_pkg::IDW-1:0];
	assign last        = cnt_q - 1'b1;
	assign rd_id       = heap_rdata[imaxpq_pkg::ELEW-1:imaxpq_pkg::KEYW];
	assign rd_key      = heap_rdata[imaxpq_pkg::KEYW-1:0];
	assign parent      = (pos_q - 1'b1) >> 1;
	assign left11      = {pos_q, 1'b1};
	assign right11     = left11 + 1'b1;
	assign left10      = left11[imaxpq_pkg::IDW-1:0];
	assign right10     = right11[imaxpq_pkg::IDW-1:0];

	assign e_wins_parent = imaxpq_pkg::outranks(e_id_q, e_key_q, rd_id, rd_key);
	assign left_wins     = imaxpq_pkg::outranks(rd_id, rd_key, e_id_q, e_key_q);
	assign right_wins    = has_right_q &&
		imaxpq_pkg::outranks(rd_id, rd_key, best_id_q, best_key_q);

	always_comb begin
		state_nxt  = state_q;
		heap_we    = 1'b0;
		heap_waddr = pos_q;
		heap_wdata = {e_id_q, e_key_q};
		heap_re    = 1'b0;
		heap_raddr = last[imaxpq_pkg::IDW-1:0];
		pm_req     = '0;
		pm_req.rd_addr = item_id;
		pm_req.wr_addr = e_id_q;
		pm_req.wr_data = {1'b1, pos_q};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					pm_req.rd_en = 1'b1;
					state_nxt    = S_MAP;
				end
			end
			S_MAP: begin
				state_nxt = S_FIN;
				unique case (act_q)
					imaxpq_pkg::ACT_INSERT: begin
						if (!map_present && cnt_q < limit) begin
							state_nxt = S_UP;
						end
					end
					imaxpq_pkg::ACT_EXTRACT: begin
						if (cnt_q != '0) begin
							pm_req.wr_en   = 1'b1;
							pm_req.wr_addr = top_id_q;
							pm_req.wr_data = '0;
							if (last != '0) begin
								heap_re   = 1'b1;
								state_nxt = S_LAST;
							end
						end
					end
					imaxpq_pkg::ACT_UPDATE: begin
						if (map_present) begin
							state_nxt = S_UP;
						end
					end
					default: begin
						if (map_present) begin
							pm_req.wr_en   = 1'b1;
							pm_req.wr_addr = id_q;
							pm_req.wr_data = '0;
							if ({1'b0, map_slot} < last) begin
								heap_re   = 1'b1;
								state_nxt = S_LAST;
							end
						end
					end
				endcase
			end
			S_LAST: begin
				state_nxt = S_UP;
			end
			S_UP: begin
				if (pos_q == '0) begin
					if (settle_q) begin
						state_nxt = S_DOWN;
					end else begin
						heap_we      = 1'b1;
						pm_req.wr_en = 1'b1;
						state_nxt    = S_FIN;
					end
				end else begin
					heap_re    = 1'b1;
					heap_raddr = parent;
					state_nxt  = S_UPCMP;
				end
			end
			S_UPCMP: begin
				if (e_wins_parent) begin
					// The parent moves down into the hole.
					heap_we        = 1'b1;
					heap_wdata     = heap_rdata;
					pm_req.wr_en   = 1'b1;
					pm_req.wr_addr = rd_id;
					state_nxt      = S_UP;
				end else if (settle_q) begin
					state_nxt = S_DOWN;
				end else begin
					heap_we      = 1'b1;
					pm_req.wr_en = 1'b1;
					state_nxt    = S_FIN;
				end
			end
			S_DOWN: begin
				if (left11 >= cnt_q) begin
					heap_we      = 1'b1;
					pm_req.wr_en = 1'b1;
					state_nxt    = S_FIN;
				end else begin
					heap_re    = 1'b1;
					heap_raddr = left10;
					state_nxt  = S_DOWNL;
				end
			end
			S_DOWNL: begin
				heap_re    = right11 < cnt_q;
				heap_raddr = right10;
				state_nxt  = S_DOWNR;
			end
			S_DOWNR: begin
				if (right_wins) begin
					heap_we        = 1'b1;
					heap_wdata     = heap_rdata;
					pm_req.wr_en   = 1'b1;
					pm_req.wr_addr = rd_id;
					state_nxt      = S_DOWN;
				end else if (bsel_q) begin
					heap_we        = 1'b1;
					heap_wdata     = {best_id_q, best_key_q};
					pm_req.wr_en   = 1'b1;
					pm_req.wr_addr = best_id_q;
					state_nxt      = S_DOWN;
				end else begin
					heap_we      = 1'b1;
					pm_req.wr_en = 1'b1;
					state_nxt    = S_FIN;
				end
			end
			S_FIN: begin
				if (rsp_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end
			if (state_q == S_MAP) begin
				unique case (act_q)
					imaxpq_pkg::ACT_INSERT: begin
						if (!map_present && cnt_q < limit) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					imaxpq_pkg::ACT_EXTRACT: begin
						if (cnt_q != '0) begin
							cnt_q <= last;
						end
					end
					imaxpq_pkg::ACT_UPDATE: begin
						cnt_q <= cnt_q;
					end
					default: begin
						if (map_present) begin
							cnt_q <= last;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (heap_we && heap_waddr == '0) begin
			top_id_q  <= heap_wdata[imaxpq_pkg::ELEW-1:imaxpq_pkg::KEYW];
			top_key_q <= heap_wdata[imaxpq_pkg::KEYW-1:0];
		end
		case (state_q)
			S_IDLE: begin
				act_q       <= action;
				id_q        <= item_id;
				key_q       <= key_value;
				taken_id_q  <= '0;
				taken_key_q <= '0;
			end
			S_MAP: begin
				status_q <= imaxpq_pkg::ST_OK;
				e_id_q   <= id_q;
				e_key_q  <= key_q;
				settle_q <= 1'b1;
				case (act_q)
					imaxpq_pkg::ACT_INSERT: begin
						settle_q <= 1'b0;
						pos_q    <= cnt_q[imaxpq_pkg::IDW-1:0];
						if (map_present) begin
							status_q <= imaxpq_pkg::ST_PRESENT;
						end else if (cnt_q >= limit) begin
							status_q <= imaxpq_pkg::ST_FULL;
						end
					end
					imaxpq_pkg::ACT_EXTRACT: begin
						pos_q <= '0;
						if (cnt_q == '0) begin
							status_q <= imaxpq_pkg::ST_EMPTY;
						end else begin
							taken_id_q  <= top_id_q;
							taken_key_q <= top_key_q;
						end
					end
					default: begin
						pos_q <= map_slot;
						if (!map_present) begin
							status_q <= imaxpq_pkg::ST_ABSENT;
						end
					end
				endcase
			end
			S_LAST: begin
				e_id_q  <= rd_id;
				e_key_q <= rd_key;
			end
			S_UPCMP: begin
				settle_q <= 1'b0;
				if (e_wins_parent) begin
					pos_q <= parent;
				end
			end
			S_DOWNL: begin
				has_right_q <= right11 < cnt_q;
				bsel_q      <= left_wins;
				if (left_wins) begin
					best_id_q  <= rd_id;
					best_key_q <= rd_key;
				end else begin
					best_id_q  <= e_id_q;
					best_key_q <= e_key_q;
				end
			end
			S_DOWNR: begin
				if (right_wins) begin
					pos_q <= right10;
				end else if (bsel_q) begin
					pos_q <= left10;
				end
			end
			S_FIN: begin
				if (rsp_free) begin
					rsp_status_q    <= status_q;
					rsp_taken_id_q  <= taken_id_q;
					rsp_taken_key_q <= taken_key_q;
					rsp_cnt_q       <= cnt_q;
					rsp_top_id_q    <= (cnt_q != '0) ? top_id_q : '0;
					rsp_top_key_q   <= (cnt_q != '0) ? top_key_q : '0;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign taken_id    = rsp_taken_id_q;
	assign taken_key   = rsp_taken_key_q;
	assign top_valid   = rsp_cnt_q != '0;
	assign top_id      = rsp_top_id_q;
	assign top_key     = rsp_top_key_q;
	assign entry_total = rsp_cnt_q;

endmodule
`default_nettype wire

// ===== design/imaxpq_chk.sv =====
// Port-level checks of the indexed max priority queue and their binding.
`default_nettype none
module imaxpq_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_stall,
	input wire logic [2:0]                         status,
	input wire logic [imaxpq_pkg::IDW-1:0]         taken_id,
	input wire logic signed [imaxpq_pkg::KEYW-1:0] taken_key,
	input wire logic                               top_valid,
	input wire logic [imaxpq_pkg::CNTW-1:0]        entry_total
);

	localparam logic [imaxpq_pkg::CNTW-1:0] SLOTS_C = imaxpq_pkg::CNTW'(imaxpq_pkg::SLOTS);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_total <= SLOTS_C) else $error("entry count beyond capacity");

	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> top_valid == (entry_total != '0)) else $error("top valid disagrees");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == imaxpq_pkg::ST_EMPTY |-> entry_total == '0)
		else $error("empty status with entries held");

	a_taken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != imaxpq_pkg::ST_OK |-> taken_id == '0 && taken_key == '0)
		else $error("taken fields set on a failed request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(entry_total))
		else $error("stalled result changed");

endmodule

bind indexed_max_priority_queue imaxpq_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.taken_id    (taken_id),
	.taken_key   (taken_key),
	.top_valid   (top_valid),
	.entry_total (entry_total)
);
`default_nettype wire
